>>> rtl/crf_pkg.sv
`timescale 1ns / 1ps

package crf_pkg;

	localparam int REPORT_MAX = 22;
	localparam int LEN_W      = 5;

	localparam logic [7:0] MODE_BTN         = 8'h30;
	localparam logic [7:0] MODE_BTN_ACC     = 8'h31;
	localparam logic [7:0] MODE_BTN_EXT8    = 8'h32;
	localparam logic [7:0] MODE_BTN_ACC_IR  = 8'h33;
	localparam logic [7:0] MODE_BTN_ACC_EXT = 8'h35;
	localparam logic [7:0] MODE_FULL        = 8'h37;

	localparam logic [LEN_W-1:0] LEN_BTN         = 5'd3;
	localparam logic [LEN_W-1:0] LEN_BTN_ACC     = 5'd6;
	localparam logic [LEN_W-1:0] LEN_BTN_EXT8    = 5'd11;
	localparam logic [LEN_W-1:0] LEN_BTN_ACC_IR  = 5'd18;
	localparam logic [LEN_W-1:0] LEN_BTN_ACC_EXT = 5'd22;
	localparam logic [LEN_W-1:0] LEN_FULL        = 5'd22;

	localparam logic [7:0] MODE_RESET = MODE_BTN;

	localparam logic REG_REPORT_MODE      = 1'b0;
	localparam logic REG_DEVICE_CONNECTED = 1'b1;

	localparam logic [9:0] IR_FILL = 10'h3FF;

	typedef struct packed {
		logic [10:0]        buttons;
		logic signed [11:0] accel_x;
		logic signed [11:0] accel_y;
		logic signed [11:0] accel_z;
		logic signed [11:0] att_accel_x;
		logic signed [11:0] att_accel_y;
		logic signed [11:0] att_accel_z;
		logic [17:0]        nunchuk_controls;
		logic [24:0]        ir_point_0;
		logic [24:0]        ir_point_1;
		logic [24:0]        ir_point_2;
		logic [24:0]        ir_point_3;
	} snapshot_t;

	typedef struct packed {
		logic [REPORT_MAX-1:0][7:0] bytes;
		logic [LEN_W-1:0]           len;
	} report_t;

endpackage

>>> rtl/crf_format.sv
`timescale 1ns / 1ps

module crf_format (
	input  crf_pkg::snapshot_t snap,
	input  logic [7:0]         report_mode,
	input  logic               device_connected,
	output crf_pkg::report_t   rpt
);

	function automatic logic [9:0] accel_code(input logic signed [11:0] v);
		logic signed [12:0] s;
		s = 13'(v) + 13'sd512;
		if (s < 13'sd0)
			return 10'd0;
		else if (s > 13'sd1023)
			return 10'd1023;
		else
			return s[9:0];
	endfunction

	logic [9:0]      mx, my, mz, ax, ay, az;
	logic [1:0][7:0] btn;
	logic [2:0][7:0] acc;
	logic [5:0][7:0] att;
	logic [11:0][7:0] irx;
	logic [9:0][7:0] irb;
	logic [3:0][24:0] pts;
	logic [3:0][9:0] px, py;
	logic [3:0]      pv;

	assign mx = accel_code(snap.accel_x);
	assign my = accel_code(snap.accel_y);
	assign mz = accel_code(snap.accel_z);
	assign ax = accel_code(snap.att_accel_x);
	assign ay = accel_code(snap.att_accel_y);
	assign az = accel_code(snap.att_accel_z);

	// button bits spread over the two-byte word, high byte first
	assign btn[0] = {snap.buttons[10], 2'b00, snap.buttons[9:5]};
	assign btn[1] = {3'b000, snap.buttons[4:0]};

	assign acc[0] = mx[9:2];
	assign acc[1] = my[9:2];
	assign acc[2] = mz[9:2];

	assign att[0] = snap.nunchuk_controls[7:0];
	assign att[1] = snap.nunchuk_controls[15:8];
	assign att[2] = ax[9:2];
	assign att[3] = ay[9:2];
	assign att[4] = az[9:2];
	assign att[5] = {az[1:0], ay[1:0], ax[1:0],
		~snap.nunchuk_controls[16], ~snap.nunchuk_controls[17]};

	assign pts = {snap.ir_point_3, snap.ir_point_2, snap.ir_point_1, snap.ir_point_0};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pv[i] = pts[i][24];
			px[i] = pv[i] ? pts[i][9:0] : crf_pkg::IR_FILL;
			py[i] = pv[i] ? pts[i][19:10] : crf_pkg::IR_FILL;
			if (pv[i]) begin
				irx[3*i]   = pts[i][7:0];
				irx[3*i+1] = pts[i][17:10];
				irx[3*i+2] = {pts[i][19:18], pts[i][9:8], pts[i][23:20]};
			end else begin
				irx[3*i]   = 8'hFF;
				irx[3*i+1] = 8'hFF;
				irx[3*i+2] = 8'hFF;
			end
		end
		for (int k = 0; k < 2; k++) begin
			if (!pv[2*k] && !pv[2*k+1]) begin
				for (int j = 0; j < 5; j++)
					irb[5*k+j] = 8'hFF;
			end else begin
				irb[5*k]   = px[2*k][7:0];
				irb[5*k+1] = py[2*k][7:0];
				irb[5*k+2] = {py[2*k][9:8], px[2*k][9:8], py[2*k+1][9:8], px[2*k+1][9:8]};
				irb[5*k+3] = px[2*k+1][7:0];
				irb[5*k+4] = py[2*k+1][7:0];
			end
		end
	end

	always_comb begin
		rpt.bytes = '0;
		rpt.len   = '0;
		rpt.bytes[0] = report_mode;
		rpt.bytes[1] = btn[0];
		rpt.bytes[2] = btn[1];
		case (report_mode)
			crf_pkg::MODE_BTN: begin
				rpt.len = crf_pkg::LEN_BTN;
			end
			crf_pkg::MODE_BTN_ACC: begin
				for (int i = 0; i < 3; i++)
					rpt.bytes[3+i] = acc[i];
				rpt.len = crf_pkg::LEN_BTN_ACC;
			end
			crf_pkg::MODE_BTN_EXT8: begin
				for (int i = 0; i < 6; i++)
					rpt.bytes[3+i] = att[i];
				rpt.len = crf_pkg::LEN_BTN_EXT8;
			end
			crf_pkg::MODE_BTN_ACC_IR: begin
				for (int i = 0; i < 3; i++)
					rpt.bytes[3+i] = acc[i];
				for (int i = 0; i < 12; i++)
					rpt.bytes[6+i] = irx[i];
				rpt.len = crf_pkg::LEN_BTN_ACC_IR;
			end
			crf_pkg::MODE_BTN_ACC_EXT: begin
				for (int i = 0; i < 3; i++)
					rpt.bytes[3+i] = acc[i];
				for (int i = 0; i < 6; i++)
					rpt.bytes[6+i] = att[i];
				rpt.len = crf_pkg::LEN_BTN_ACC_EXT;
			end
			crf_pkg::MODE_FULL: begin
				for (int i = 0; i < 3; i++)
					rpt.bytes[3+i] = acc[i];
				for (int i = 0; i < 10; i++)
					rpt.bytes[6+i] = irb[i];
				for (int i = 0; i < 6; i++)
					rpt.bytes[16+i] = att[i];
				rpt.len = crf_pkg::LEN_FULL;
			end
			default: begin
				rpt.len = '0;
			end
		endcase
		if (!device_connected)
			rpt.len = '0;
	end

endmodule

>>> rtl/crf_serializer.sv
`timescale 1ns / 1ps

module crf_serializer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  crf_pkg::report_t       rpt,
	output logic                   free,
	output logic                   strobe,
	output logic [7:0]             report_byte,
	output logic                   last
);

	logic [crf_pkg::REPORT_MAX-1:0][7:0] buf_q;
	logic [crf_pkg::LEN_W-1:0]           cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= rpt.len;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= rpt.bytes;
		end else if (cnt_q != '0) begin
			buf_q <= {8'h00, buf_q[crf_pkg::REPORT_MAX-1:1]};
		end
	end

	// free when idle or on the final beat
	assign free        = (cnt_q <= crf_pkg::LEN_W'(1));
	assign strobe      = (cnt_q != '0);
	assign report_byte = buf_q[0];
	assign last        = (cnt_q == crf_pkg::LEN_W'(1));

`ifndef ASSERT_OFF
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && !load |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("beat count did not step down");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("report loaded over one still going out");
`endif

endmodule

>>> rtl/controller_input_report_formatter.sv
`timescale 1ns / 1ps
// channel   | ports                                           | handshake
// snapshot  | buttons .. ir_point_3                           | start & !busy
// report    | report_byte, last                               | strobe, one beat per cycle
// config    | psel penable pwrite paddr pwdata prdata pready  | apb, pready tied high
//
// a snapshot is registered on acceptance; its report is loaded into the byte
// shifter when that is free and leaves one beat per cycle: 3 to 22 beats by
// report_mode, none for an unknown mode or device_connected 0. one snapshot
// can be held, and accepted, while the previous report still drains.
// reset: report_mode 0x30, device_connected 0, no snapshot held, no beats.
// the receiver cannot stall; busy is high only while a held snapshot waits.

module controller_input_report_formatter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [10:0]        buttons,
	input  logic signed [11:0] accel_x,
	input  logic signed [11:0] accel_y,
	input  logic signed [11:0] accel_z,
	input  logic signed [11:0] att_accel_x,
	input  logic signed [11:0] att_accel_y,
	input  logic signed [11:0] att_accel_z,
	input  logic [17:0]        nunchuk_controls,
	input  logic [24:0]        ir_point_0,
	input  logic [24:0]        ir_point_1,
	input  logic [24:0]        ir_point_2,
	input  logic [24:0]        ir_point_3,
	output logic               strobe,
	output logic [7:0]         report_byte,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic               valid_s1;
	crf_pkg::snapshot_t snap_s1;
	logic [7:0]         mode_q;
	logic               conn_q;
	logic               accept, load, free, wr;
	crf_pkg::report_t   rpt;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == crf_pkg::REG_REPORT_MODE) ? {24'h0, mode_q} : {31'h0, conn_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= crf_pkg::MODE_RESET;
			conn_q <= 1'b0;
		end else if (wr) begin
			if (paddr[2] == crf_pkg::REG_REPORT_MODE)
				mode_q <= pwdata[7:0];
			else
				conn_q <= pwdata[0];
		end
	end

	assign load   = valid_s1 && free;
	assign busy   = valid_s1 && !free;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			snap_s1 <= '{buttons, accel_x, accel_y, accel_z, att_accel_x, att_accel_y,
				att_accel_z, nunchuk_controls, ir_point_0, ir_point_1, ir_point_2,
				ir_point_3};
		end
	end

	crf_format u_format (
		.snap             (snap_s1),
		.report_mode      (mode_q),
		.device_connected (conn_q),
		.rpt              (rpt)
	);

	crf_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.rpt         (rpt),
		.free        (free),
		.strobe      (strobe),
		.report_byte (report_byte),
		.last        (last)
	);

`ifndef ASSERT_OFF
	a_busy_held: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1 && strobe)
		else $error("busy without a held snapshot behind a running report");
	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted snapshot not held");
	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last marker outside a beat");
`endif

endmodule
